// ===== hw/rtl/bbtc_pkg.sv =====
`default_nettype none

package bbtc_pkg;

   typedef enum logic [2:0] {
      OP_OPEN,
      OP_CLOSE,
      OP_DATA,
      OP_NACK,
      OP_ACK,
      OP_SEND,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] seq;
      logic [1:0] first_byte;
   } cmd_type;

   typedef struct packed {
      logic [15:0] idle_ticks;
      logic [15:0] ack_ticks;
      logic [2:0]  max_repeats;
   } csr_type;

   localparam logic [15:0] IDLE_TICKS_RESET  = 16'd6000;
   localparam logic [15:0] ACK_TICKS_RESET   = 16'd3000;
   localparam logic [2:0]  MAX_REPEATS_RESET = 3'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/bbtc_req_if.sv =====
`default_nettype none

interface bbtc_req_if #(
   parameter int TAG_BITS = 8
) ();
   logic                valid;
   logic                ready;
   logic [2:0]          action;
   logic [2:0]          pdu_kind;
   logic [3:0]          seq_no;
   logic [TAG_BITS-1:0] msg_tag;
   logic [7:0]          first_byte;

   modport source (
      output valid, action, pdu_kind, seq_no, msg_tag, first_byte,
      input  ready
   );
   modport sink (
      input  valid, action, pdu_kind, seq_no, msg_tag, first_byte,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/bbtc_rsp_if.sv =====
`default_nettype none

interface bbtc_rsp_if #(
   parameter int TAG_BITS = 8
) ();
   logic                valid;
   logic                ready;
   logic [2:0]          out_kind;
   logic [3:0]          out_seq;
   logic [TAG_BITS-1:0] out_tag;
   logic [1:0]          out_first_byte;
   logic                last;

   modport source (
      output valid, out_kind, out_seq, out_tag, out_first_byte, last,
      input  ready
   );
   modport sink (
      input  valid, out_kind, out_seq, out_tag, out_first_byte, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/building_bus_transport_connection_core.sv =====
// The first result of a transaction is offered from the result registers once it has
// passed the two-entry front queue and been executed; a busy result port holds it back.
// Throughput: one transaction per cycle while each causes at most one result and the
// port is ready; two results hold back the next, as it hands out one per cycle.
// Reset is synchronous: the connection closes, counters and the tag queue empty and the
// timeout and repeat registers return to 6000, 3000 and 3; the tag store is not cleared.
`default_nettype none

module building_bus_transport_connection_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   bbtc_req_if.sink         req_bus,
   bbtc_rsp_if.source       rsp_bus
);

   localparam logic [1:0] CSR_IDLE_TICKS  = 2'd0;
   localparam logic [1:0] CSR_ACK_TICKS   = 2'd1;
   localparam logic [1:0] CSR_MAX_REPEATS = 2'd2;

   bbtc_pkg::csr_type   csr_ff;
   logic                cmd_valid;
   bbtc_pkg::cmd_type   cmd;
   logic [TAG_BITS-1:0] cmd_tag;
   logic                cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.idle_ticks  <= bbtc_pkg::IDLE_TICKS_RESET;
         csr_ff.ack_ticks   <= bbtc_pkg::ACK_TICKS_RESET;
         csr_ff.max_repeats <= bbtc_pkg::MAX_REPEATS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IDLE_TICKS:  csr_ff.idle_ticks  <= csr_wdata;
            CSR_ACK_TICKS:   csr_ff.ack_ticks   <= csr_wdata;
            CSR_MAX_REPEATS: csr_ff.max_repeats <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   bbtc_front #(
      .TAG_BITS (TAG_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_tag   (cmd_tag),
      .cmd_pop   (cmd_pop)
   );

   bbtc_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_tag   (cmd_tag),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bbtc_front.sv =====
`default_nettype none

module bbtc_front #(
   parameter int TAG_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bbtc_req_if.sink                  req_bus,
   output logic                      cmd_valid,
   output bbtc_pkg::cmd_type         cmd,
   output logic [TAG_BITS-1:0]       cmd_tag,
   input  wire logic                 cmd_pop
);

   typedef enum logic [2:0] {
      ACT_OPEN  = 3'd0,
      ACT_FRAME = 3'd1,
      ACT_SEND  = 3'd2,
      ACT_TICK  = 3'd3,
      ACT_CLOSE = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      PDU_DISCONNECT = 3'd0,
      PDU_CONNECT    = 3'd1,
      PDU_DATA       = 3'd2,
      PDU_NACK       = 3'd3,
      PDU_ACK        = 3'd4
   } pdu_type;

   bbtc_pkg::cmd_type   entry_ff [2];
   logic [TAG_BITS-1:0] tag_ff   [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   bbtc_pkg::op_type    op;
   logic                keep;
   logic                push;

   always_comb begin
      keep = 1'b1;
      op   = bbtc_pkg::OP_CLOSE;
      unique case (req_bus.action)
         ACT_OPEN:  op = bbtc_pkg::OP_OPEN;
         ACT_FRAME: begin
            unique case (req_bus.pdu_kind) inside
               PDU_DISCONNECT, PDU_CONNECT: op = bbtc_pkg::OP_CLOSE;
               PDU_DATA:                    op = bbtc_pkg::OP_DATA;
               PDU_NACK:                    op = bbtc_pkg::OP_NACK;
               PDU_ACK:                     op = bbtc_pkg::OP_ACK;
               default:                     keep = 1'b0;
            endcase
         end
         ACT_SEND:  op = bbtc_pkg::OP_SEND;
         ACT_TICK:  op = bbtc_pkg::OP_TICK;
         ACT_CLOSE: op = bbtc_pkg::OP_CLOSE;
         default:   keep = 1'b0;
      endcase
   end

   // Transactions that can never cause a result are consumed here and not queued.
   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready && keep;

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].op         <= op;
         entry_ff[wr_ptr_ff].seq        <= req_bus.seq_no;
         entry_ff[wr_ptr_ff].first_byte <= req_bus.first_byte[1:0];
         tag_ff[wr_ptr_ff]              <= req_bus.msg_tag;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign cmd_tag   = tag_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== hw/rtl/bbtc_back.sv =====
`default_nettype none

module bbtc_back #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bbtc_pkg::csr_type    csr,
   input  wire logic                 cmd_valid,
   input  wire bbtc_pkg::cmd_type    cmd,
   input  wire logic [TAG_BITS-1:0]  cmd_tag,
   output logic                      cmd_pop,
   bbtc_rsp_if.source                rsp_bus
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 1;

   typedef enum logic [1:0] {
      MODE_CLOSED = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_WAIT   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      KIND_CONNECT    = 3'd0,
      KIND_DISCONNECT = 3'd1,
      KIND_ACK        = 3'd2,
      KIND_DATA       = 3'd3,
      KIND_DELIVER    = 3'd4,
      KIND_CLOSED     = 3'd5,
      KIND_REJECT     = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] seq;
      logic       from_mem;
      logic       from_cmd;
      logic [1:0] first_byte;
   } result_type;

   mode_type            mode_ff, mode_in;
   logic [3:0]          send_seq_ff, send_seq_in;
   logic [3:0]          recv_seq_ff, recv_seq_in;
   logic [2:0]          repeat_ff, repeat_in;
   logic [15:0]         timer_ff, timer_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;

   logic [1:0]          left_ff;
   logic                sel_ff;
   result_type          res_ff [2];
   result_type          res_in [2];
   logic [1:0]          num_res;
   logic [TAG_BITS-1:0] cmd_tag_ff;
   logic                bypass_ff, bypass_in;
   logic [TAG_BITS-1:0] rd_data_ff;
   logic [TAG_BITS-1:0] tags_mem [QUEUE_DEPTH];

   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;
   logic [SW-1:0]       tail_sum;
   logic                do_shut, do_repeat, do_start;
   logic                fire;
   logic [TAG_BITS-1:0] mem_tag;
   result_type          cur;

   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign wr_addr  = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : AW'(tail_sum);

   always_comb begin
      mode_in     = mode_ff;
      send_seq_in = send_seq_ff;
      recv_seq_in = recv_seq_ff;
      repeat_in   = repeat_ff;
      timer_in    = timer_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      res_in[0]   = '0;
      res_in[1]   = '0;
      num_res     = 2'd0;
      rd_addr     = head_ff;
      wr_en       = 1'b0;
      bypass_in   = 1'b0;
      do_shut     = 1'b0;
      do_repeat   = 1'b0;
      do_start    = 1'b0;

      case (cmd.op)
         bbtc_pkg::OP_OPEN: begin
            if (mode_ff == MODE_CLOSED) begin
               res_in[0].kind = KIND_CONNECT;
               num_res        = 2'd1;
               mode_in        = MODE_IDLE;
               send_seq_in    = 4'd0;
               recv_seq_in    = 4'd0;
               repeat_in      = 3'd0;
               timer_in       = csr.idle_ticks;
               do_start       = 1'b1;
            end
         end
         bbtc_pkg::OP_CLOSE: begin
            do_shut = (mode_ff != MODE_CLOSED);
         end
         bbtc_pkg::OP_DATA: begin
            if (mode_ff != MODE_CLOSED) begin
               if (cmd.seq == recv_seq_ff) begin
                  res_in[0].kind       = KIND_DELIVER;
                  res_in[0].from_cmd   = 1'b1;
                  res_in[0].first_byte = cmd.first_byte;
                  res_in[1].kind       = KIND_ACK;
                  res_in[1].seq        = recv_seq_ff;
                  num_res              = 2'd2;
                  recv_seq_in          = recv_seq_ff + 4'd1;
               end else if (cmd.seq == recv_seq_ff - 4'd1) begin
                  res_in[0].kind = KIND_ACK;
                  res_in[0].seq  = cmd.seq;
                  num_res        = 2'd1;
               end else begin
                  do_shut = 1'b1;
               end
               if (!do_shut && mode_ff == MODE_IDLE) begin
                  timer_in = csr.idle_ticks;
               end
            end
         end
         bbtc_pkg::OP_NACK: begin
            if (mode_ff != MODE_CLOSED) begin
               if (cmd.seq != send_seq_ff || count_ff == '0) begin
                  do_shut = 1'b1;
               end else begin
                  do_repeat = 1'b1;
               end
            end
         end
         bbtc_pkg::OP_ACK: begin
            if (mode_ff != MODE_CLOSED) begin
               if (cmd.seq != send_seq_ff || mode_ff != MODE_WAIT || count_ff == '0) begin
                  do_shut = 1'b1;
               end else begin
                  timer_in    = csr.idle_ticks;
                  mode_in     = MODE_IDLE;
                  head_in     = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
                  count_in    = count_ff - CW'(1);
                  send_seq_in = send_seq_ff + 4'd1;
                  do_start    = 1'b1;
               end
            end
         end
         bbtc_pkg::OP_SEND: begin
            if (count_ff == CW'(QUEUE_DEPTH)) begin
               res_in[0].kind = KIND_REJECT;
               num_res        = 2'd1;
            end else begin
               wr_en     = 1'b1;
               count_in  = count_ff + CW'(1);
               bypass_in = (count_ff == '0);
               do_start  = (mode_ff == MODE_IDLE);
            end
         end
         bbtc_pkg::OP_TICK: begin
            if (mode_ff != MODE_CLOSED) begin
               if (timer_ff > 16'd1) begin
                  timer_in = timer_ff - 16'd1;
               end else begin
                  timer_in  = 16'd0;
                  do_repeat = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_repeat) begin
         if (mode_ff == MODE_WAIT && count_ff != '0 && repeat_ff < csr.max_repeats) begin
            repeat_in          = repeat_ff + 3'd1;
            timer_in           = csr.ack_ticks;
            res_in[0].kind     = KIND_DATA;
            res_in[0].seq      = send_seq_ff;
            res_in[0].from_mem = 1'b1;
            num_res            = 2'd1;
         end else begin
            do_shut = 1'b1;
         end
      end

      if (do_shut) begin
         mode_in        = MODE_CLOSED;
         res_in[0]      = '0;
         res_in[1]      = '0;
         res_in[0].kind = KIND_DISCONNECT;
         res_in[1].kind = KIND_CLOSED;
         num_res        = 2'd2;
      end

      if (do_start && count_in != '0) begin
         repeat_in                   = 3'd0;
         mode_in                     = MODE_WAIT;
         timer_in                    = csr.ack_ticks;
         rd_addr                     = head_in;
         res_in[num_res[0]].kind     = KIND_DATA;
         res_in[num_res[0]].seq      = send_seq_in;
         res_in[num_res[0]].from_mem = 1'b1;
         num_res                     = num_res + 2'd1;
      end
   end

   assign fire    = cmd_valid && (left_ff == 2'd0 || (left_ff == 2'd1 && rsp_bus.ready));
   assign cmd_pop = fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_CLOSED;
         send_seq_ff <= 4'd0;
         recv_seq_ff <= 4'd0;
         repeat_ff   <= 3'd0;
         timer_ff    <= 16'd0;
         head_ff     <= '0;
         count_ff    <= '0;
         left_ff     <= 2'd0;
         sel_ff      <= 1'b0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         send_seq_ff <= send_seq_in;
         recv_seq_ff <= recv_seq_in;
         repeat_ff   <= repeat_in;
         timer_ff    <= timer_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         left_ff     <= num_res;
         sel_ff      <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         left_ff <= left_ff - 2'd1;
         sel_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff[0]  <= res_in[0];
         res_ff[1]  <= res_in[1];
         cmd_tag_ff <= cmd_tag;
         bypass_ff  <= bypass_in;
      end
   end

   // The tag being sent is read as the transaction is executed; a tag written by the
   // same transaction into an empty store is taken from the command instead.
   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         tags_mem[wr_addr] <= cmd_tag;
      end
      if (fire) begin
         rd_data_ff <= tags_mem[rd_addr];
      end
   end

   assign mem_tag = bypass_ff ? cmd_tag_ff : rd_data_ff;
   assign cur     = res_ff[sel_ff];

   assign rsp_bus.valid          = (left_ff != 2'd0);
   assign rsp_bus.out_kind       = cur.kind;
   assign rsp_bus.out_seq        = cur.seq;
   assign rsp_bus.out_tag        = cur.from_mem ? mem_tag : (cur.from_cmd ? cmd_tag_ff : '0);
   assign rsp_bus.out_first_byte = cur.first_byte;
   assign rsp_bus.last           = (left_ff == 2'd1);

endmodule

`default_nettype wire
